// ===== rtl/snc_pkg.sv =====
// ----------------------------------------------------------------------------
// snc_pkg
// Shared types, constants and character helpers for the sensor node command
// scheduler.
// ----------------------------------------------------------------------------
package snc_pkg;

  // Frame buffer geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int BUF_LW       = $clog2(BUFFER_DEPTH + 1);

  // Period handling
  localparam logic [15:0] PERIOD_RESET = 16'd500;
  localparam logic [15:0] PERIOD_LIMIT = 16'd1000;

  // Multipliers for the shared multiply-add unit
  localparam int          MUL_W      = 7;
  localparam logic [6:0]  MUL_DIGIT  = 7'd10;
  localparam logic [6:0]  MUL_PERIOD = 7'd100;

  // Item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Command characters
  localparam logic [7:0] CHR_OPEN  = 8'h73;  // 's'
  localparam logic [7:0] CHR_CLOSE = 8'h65;  // 'e'
  localparam logic [7:0] CHR_ON    = 8'h42;  // 'B'
  localparam logic [7:0] CHR_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CHR_T     = 8'h54;  // 'T'
  localparam logic [7:0] CHR_P     = 8'h50;  // 'P'
  localparam logic [7:0] CHR_H     = 8'h48;  // 'H'
  localparam logic [7:0] CHR_SLASH = 8'h2f;  // '/'

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_char;
  } snc_in_t;

  typedef struct packed {
    logic read_temp;
    logic read_humi;
    logic read_press;
    logic show_th_off;
    logic show_press_off;
    logic power_off_th;
    logic power_off_press;
    logic wake_th;
    logic wake_press;
    logic command_done;
    logic rx_overflow;
  } snc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_COMMIT,
    ST_FINISH
  } snc_state_t;

  // Which period value the digits currently extend
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_T,
    SEL_P,
    SEL_H
  } snc_sel_t;

  // Commit order of the three periods
  typedef enum logic [1:0] {
    CM_TEMP,
    CM_HUMI,
    CM_PRESS
  } snc_commit_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_accepted(input logic [7:0] ch);
    return ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a)) ||
           is_digit(ch) || (ch == CHR_SLASH);
  endfunction

endpackage

// ===== rtl/snc_ram.sv =====
// ----------------------------------------------------------------------------
// snc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/snc_alu.sv =====
// ----------------------------------------------------------------------------
// snc_alu
// Shared multiply-add unit: y = (a * mul + add) modulo 2^16. Serves both the
// decimal digit accumulation and the period scaling.
// ----------------------------------------------------------------------------
module snc_alu
  import snc_pkg::*;
(
  input  logic [15:0]      a,
  input  logic [MUL_W-1:0] mul,
  input  logic [3:0]       add,
  output logic [15:0]      y
);

  logic [15+MUL_W:0] prod;

  // Multiply, keep the low 16 bits, add the digit
  assign prod = {{MUL_W{1'b0}}, a} * {16'd0, mul};
  assign y    = prod[15:0] + {12'd0, add};

endmodule

// ===== rtl/sensor_node_command_scheduler.sv =====
// ----------------------------------------------------------------------------
// sensor_node_command_scheduler
// A tick or an ordinary byte is registered and its result goes to the output
// register; a closing 'e' first walks the buffered characters, one character
// per cycle through the shared multiply-add unit, then for a long command
// commits the three periods on the same unit. One item at a time: the next
// transfer is taken once the item has moved to the output register. Reset
// clears the control state; the working registers are not reset.
// ----------------------------------------------------------------------------
module sensor_node_command_scheduler
  import snc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  snc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output snc_out_t out_data
);

  // State registers
  snc_state_t           state_r, state_nxt;
  snc_in_t              in_r, in_nxt;
  logic                 frame_open_r, frame_open_nxt;
  logic [BUF_LW-1:0]    len_r, len_nxt;
  logic [BUFFER_DEPTH-1:0] vld_r, vld_nxt;
  logic [15:0]          period_t_r, period_t_nxt, period_h_r, period_h_nxt;
  logic [15:0]          period_p_r, period_p_nxt;
  logic [15:0]          saved_t_r, saved_t_nxt, saved_h_r, saved_h_nxt;
  logic [15:0]          saved_p_r, saved_p_nxt;
  logic [15:0]          tick_t_r, tick_t_nxt, tick_h_r, tick_h_nxt;
  logic [15:0]          tick_p_r, tick_p_nxt;
  logic                 chan_th_r, chan_th_nxt, chan_p_r, chan_p_nxt;
  logic                 shown_th_r, shown_th_nxt, shown_p_r, shown_p_nxt;
  logic                 short_r, short_nxt;
  logic [BUF_LW-1:0]    k_r, k_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [BUF_AW-1:0]    rd_addr_r, rd_addr_nxt;
  snc_sel_t             sel_r, sel_nxt;
  logic [15:0]          vt_r, vt_nxt, vp_r, vp_nxt, vh_r, vh_nxt;
  logic                 on_r, on_nxt, one_r, one_nxt;
  snc_commit_t          cm_r, cm_nxt;
  logic                 out_valid_r, out_valid_nxt;
  snc_out_t             out_r, out_nxt;

  // Datapath signals
  logic                 ram_we;
  logic [7:0]           ram_q;
  logic [7:0]           rd_data;
  logic [15:0]          alu_a, alu_y;
  logic [MUL_W-1:0]     alu_mul;
  logic [3:0]           alu_add;
  logic [15:0]          cm_val;
  logic                 cm_ok;
  logic [BUF_LW-1:0]    walk_len;
  logic                 out_free;
  logic [15:0]          tt, th, tp;
  snc_out_t             res;

  // Frame buffer
  snc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[BUF_AW-1:0]),
    .wdata (in_r.rx_char),
    .raddr (k_r[BUF_AW-1:0]),
    .rdata (ram_q)
  );

  // Entries never written since reset read as zero
  assign rd_data = rd_ok_r ? ram_q : 8'h00;

  // Select the value under commit
  always_comb begin
    case (cm_r)
      CM_TEMP:  cm_val = vt_r;
      CM_HUMI:  cm_val = vh_r;
      CM_PRESS: cm_val = vp_r;
      default:  cm_val = vp_r;
    endcase
  end

  assign cm_ok = (cm_val != 16'd0) && (cm_val < PERIOD_LIMIT);

  // Feed the shared unit: digit step while walking, scaling while committing
  always_comb begin
    alu_a   = cm_val;
    alu_mul = MUL_PERIOD;
    alu_add = 4'd0;
    if (state_r == ST_WALK) begin
      alu_mul = MUL_DIGIT;
      alu_add = rd_data[3:0];
      case (sel_r)
        SEL_T:   alu_a = vt_r;
        SEL_P:   alu_a = vp_r;
        SEL_H:   alu_a = vh_r;
        default: alu_a = 16'd0;
      endcase
    end
  end

  snc_alu u_alu (
    .a   (alu_a),
    .mul (alu_mul),
    .add (alu_add),
    .y   (alu_y)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign walk_len = short_r ? BUF_LW'(2) : len_r;
  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    frame_open_nxt = frame_open_r;
    len_nxt        = len_r;
    vld_nxt        = vld_r;
    period_t_nxt   = period_t_r;
    period_h_nxt   = period_h_r;
    period_p_nxt   = period_p_r;
    saved_t_nxt    = saved_t_r;
    saved_h_nxt    = saved_h_r;
    saved_p_nxt    = saved_p_r;
    tick_t_nxt     = tick_t_r;
    tick_h_nxt     = tick_h_r;
    tick_p_nxt     = tick_p_r;
    chan_th_nxt    = chan_th_r;
    chan_p_nxt     = chan_p_r;
    shown_th_nxt   = shown_th_r;
    shown_p_nxt    = shown_p_r;
    short_nxt      = short_r;
    k_nxt          = k_r;
    rd_pend_nxt    = 1'b0;
    rd_ok_nxt      = vld_r[k_r[BUF_AW-1:0]];
    rd_addr_nxt    = k_r[BUF_AW-1:0];
    sel_nxt        = sel_r;
    vt_nxt         = vt_r;
    vp_nxt         = vp_r;
    vh_nxt         = vh_r;
    on_nxt         = on_r;
    one_nxt        = one_r;
    cm_nxt         = cm_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    res            = '0;
    tt             = tick_t_r;
    th             = tick_h_r;
    tp             = tick_p_r;

    case (state_r)
      // Take one item
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = ST_DISPATCH;
        end
      end

      // Handle ticks and ordinary bytes; start the walk on a closing byte
      ST_DISPATCH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (in_r.mode == MODE_TICK) begin
            if (chan_th_r) begin
              res.read_temp = (tick_t_r == 16'd0);
              res.read_humi = (tick_h_r == 16'd0);
              tt = tick_t_r + 16'd1;
              th = tick_h_r + 16'd1;
            end else if (!shown_th_r) begin
              res.show_th_off = 1'b1;
              tt = 16'd0;
              th = 16'd0;
              shown_th_nxt = 1'b1;
            end
            if (chan_p_r) begin
              res.read_press = (tick_p_r == 16'd0);
              tp = tick_p_r + 16'd1;
            end else if (!shown_p_r) begin
              res.show_press_off = 1'b1;
              tp = 16'd0;
              shown_p_nxt = 1'b1;
            end
            tick_t_nxt = (tt >= period_t_r) ? 16'd0 : tt;
            tick_h_nxt = (th >= period_h_r) ? 16'd0 : th;
            tick_p_nxt = (tp >= period_p_r) ? 16'd0 : tp;
          end else if (is_accepted(in_r.rx_char)) begin
            if ((in_r.rx_char == CHR_OPEN) && !frame_open_r) begin
              frame_open_nxt = 1'b1;
              len_nxt        = '0;
            end else if (frame_open_r && (in_r.rx_char == CHR_CLOSE)) begin
              frame_open_nxt = 1'b0;
              short_nxt      = (len_r <= BUF_LW'(2));
              k_nxt          = '0;
              sel_nxt        = SEL_NONE;
              vt_nxt         = 16'd0;
              vp_nxt         = 16'd0;
              vh_nxt         = 16'd0;
              state_nxt      = ST_WALK;
            end else if (frame_open_r) begin
              if (len_r < BUF_LW'(BUFFER_DEPTH)) begin
                ram_we  = 1'b1;
                vld_nxt[len_r[BUF_AW-1:0]] = 1'b1;
                len_nxt = len_r + BUF_LW'(1);
              end else begin
                res.rx_overflow = 1'b1;
              end
            end
          end
          res.power_off_th    = !chan_th_r;
          res.power_off_press = !chan_p_r;
          if (state_nxt == ST_IDLE) begin
            out_valid_nxt = 1'b1;
            out_nxt       = res;
          end
        end
      end

      // Read one buffered character per cycle, process the one read before
      ST_WALK: begin
        if (k_r < walk_len) begin
          k_nxt       = k_r + BUF_LW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = short_r ? ST_FINISH : ST_COMMIT;
          cm_nxt    = CM_TEMP;
        end
        if (rd_pend_r) begin
          if (short_r) begin
            if (rd_addr_r == '0) begin
              on_nxt = (rd_data == CHR_ON);
            end else begin
              one_nxt = (rd_data == CHR_ONE);
            end
          end else if (is_digit(rd_data)) begin
            case (sel_r)
              SEL_T:   vt_nxt = alu_y;
              SEL_P:   vp_nxt = alu_y;
              SEL_H:   vh_nxt = alu_y;
              default: vt_nxt = vt_r;
            endcase
          end else if (rd_data == CHR_T) begin
            sel_nxt = SEL_T;
          end else if (rd_data == CHR_P) begin
            sel_nxt = SEL_P;
          end else if (rd_data == CHR_H) begin
            sel_nxt = SEL_H;
          end
        end
      end

      // Scale and store one period per cycle
      ST_COMMIT: begin
        case (cm_r)
          CM_TEMP: begin
            period_t_nxt = cm_ok ? alu_y : saved_t_r;
            saved_t_nxt  = cm_ok ? alu_y : saved_t_r;
            cm_nxt       = CM_HUMI;
          end
          CM_HUMI: begin
            period_h_nxt = cm_ok ? alu_y : saved_h_r;
            saved_h_nxt  = cm_ok ? alu_y : saved_h_r;
            cm_nxt       = CM_PRESS;
          end
          default: begin
            period_p_nxt = cm_ok ? alu_y : saved_p_r;
            saved_p_nxt  = cm_ok ? alu_y : saved_p_r;
            state_nxt    = ST_FINISH;
          end
        endcase
      end

      // Apply a channel command or clear the counters, then report
      ST_FINISH: begin
        if (out_free) begin
          if (short_r) begin
            if (on_r && one_r) begin
              chan_th_nxt  = 1'b1;
              res.wake_th  = 1'b1;
              period_t_nxt = saved_t_r;
              period_h_nxt = saved_h_r;
            end else if (on_r) begin
              chan_p_nxt     = 1'b1;
              res.wake_press = 1'b1;
              period_p_nxt   = saved_p_r;
            end else if (one_r) begin
              chan_th_nxt  = 1'b0;
              shown_th_nxt = 1'b0;
              tick_t_nxt   = 16'd0;
              tick_h_nxt   = 16'd0;
            end else begin
              chan_p_nxt  = 1'b0;
              shown_p_nxt = 1'b0;
              tick_p_nxt  = 16'd0;
            end
          end else begin
            tick_t_nxt = 16'd0;
            tick_h_nxt = 16'd0;
            tick_p_nxt = 16'd0;
          end
          res.command_done    = 1'b1;
          res.power_off_th    = !chan_th_nxt;
          res.power_off_press = !chan_p_nxt;
          out_valid_nxt       = 1'b1;
          out_nxt             = res;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_open_r <= 1'b0;
      len_r        <= '0;
      vld_r        <= '0;
      period_t_r   <= PERIOD_RESET;
      period_h_r   <= PERIOD_RESET;
      period_p_r   <= PERIOD_RESET;
      saved_t_r    <= PERIOD_RESET;
      saved_h_r    <= PERIOD_RESET;
      saved_p_r    <= PERIOD_RESET;
      tick_t_r     <= 16'd0;
      tick_h_r     <= 16'd0;
      tick_p_r     <= 16'd0;
      chan_th_r    <= 1'b1;
      chan_p_r     <= 1'b1;
      shown_th_r   <= 1'b0;
      shown_p_r    <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_open_r <= frame_open_nxt;
      len_r        <= len_nxt;
      vld_r        <= vld_nxt;
      period_t_r   <= period_t_nxt;
      period_h_r   <= period_h_nxt;
      period_p_r   <= period_p_nxt;
      saved_t_r    <= saved_t_nxt;
      saved_h_r    <= saved_h_nxt;
      saved_p_r    <= saved_p_nxt;
      tick_t_r     <= tick_t_nxt;
      tick_h_r     <= tick_h_nxt;
      tick_p_r     <= tick_p_nxt;
      chan_th_r    <= chan_th_nxt;
      chan_p_r     <= chan_p_nxt;
      shown_th_r   <= shown_th_nxt;
      shown_p_r    <= shown_p_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    short_r   <= short_nxt;
    k_r       <= k_nxt;
    rd_ok_r   <= rd_ok_nxt;
    rd_addr_r <= rd_addr_nxt;
    sel_r     <= sel_nxt;
    vt_r      <= vt_nxt;
    vp_r      <= vp_nxt;
    vh_r      <= vh_nxt;
    on_r      <= on_nxt;
    one_r     <= one_nxt;
    cm_r      <= cm_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/snc_checker.sv =====
// ----------------------------------------------------------------------------
// snc_checker
// Port-level checks for the sensor node command scheduler, bound to the top.
// ----------------------------------------------------------------------------
module snc_checker
  import snc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input snc_out_t out_data
);

  // Stall the input right after each transfer while the item is processed
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in process");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Tick results carry no byte-side flags
  a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_temp || out_data.read_humi || out_data.read_press ||
                  out_data.show_th_off || out_data.show_press_off)
    |-> !out_data.command_done && !out_data.rx_overflow &&
        !out_data.wake_th && !out_data.wake_press)
    else $error("tick result mixed with byte flags");

  // Wake only comes with a closed command and a powered channel
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.wake_th || out_data.wake_press)
    |-> out_data.command_done && !out_data.rx_overflow &&
        !(out_data.wake_th && out_data.power_off_th) &&
        !(out_data.wake_press && out_data.power_off_press))
    else $error("wake without command or channel still off");

  // Off text only while the channel is off and not sampled
  a_off_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.show_th_off
    |-> out_data.power_off_th && !out_data.read_temp && !out_data.read_humi)
    else $error("off text on an active channel");

endmodule

bind sensor_node_command_scheduler snc_checker u_snc_checker (.*);
